### rtl/core/refcounted_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block allocator
// Shared helpers for the concurrent checks, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_BLOCK_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define RCBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, quiet while reset is high.
`define RCBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication that also holds across reset.
`define RCBA_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### rtl/core/rcba_pkg.sv
// ----------------------------------------------------------------------------
// rcba_pkg
// Types, codes and defaults shared by the block allocator modules.
// ----------------------------------------------------------------------------
package rcba_pkg;

  // Default sizes of the pool and its counters.
  localparam int POOL_CAPACITY = 1024;
  localparam int REF_WIDTH     = 16;
  localparam int MAX_ALLOC     = 64;
  localparam int QUEUE_DEPTH   = 2;
  localparam int BC_DEFAULT    = 1024;

  // Field widths of the transaction ports.
  localparam int OP_W  = 3;
  localparam int ID_W  = 10;
  localparam int CNT_W = 7;
  localparam int BC_W  = 11;
  localparam int ST_W  = 2;
  localparam int TOT_W = 10;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC      = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE_REQ   = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE_CACHE = 3'd2;
  localparam logic [OP_W-1:0] OP_REF_REQ    = 3'd3;
  localparam logic [OP_W-1:0] OP_REF_CACHE  = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_SHORT = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

  // Register index of block_count.
  localparam logic REG_BLOCK_COUNT = 1'b0;

  // Classified command kinds.
  typedef enum logic [2:0] {
    K_ALLOC,
    K_ZERO,
    K_SHORT,
    K_BAD,
    K_FREE_REQ,
    K_FREE_CACHE,
    K_REF_REQ,
    K_REF_CACHE
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  target_id;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  granted_block;
    logic             last;
    logic [ST_W-1:0]  status;
    logic [TOT_W-1:0] free_blocks;
    logic [TOT_W-1:0] available_blocks;
  } result_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ONE,
    S_AROW,
    S_APICK,
    S_AUPD,
    S_ERD,
    S_EPUSH,
    S_RMW_RD,
    S_RMW_EX
  } state_t;

endpackage

### rtl/core/rcba_fifo.sv
// ----------------------------------------------------------------------------
// rcba_fifo
// Small register queue used between the front and back and at the results.
// ----------------------------------------------------------------------------
module rcba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rcba_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == FILL_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Payload storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end
endmodule

### rtl/core/rcba_front.sv
// ----------------------------------------------------------------------------
// rcba_front
// Accepts input transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
module rcba_front #(
  parameter int MAX_ALLOC = rcba_pkg::MAX_ALLOC
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [rcba_pkg::OP_W-1:0]  operation,
  input  logic [rcba_pkg::ID_W-1:0]  target_id,
  input  logic [rcba_pkg::CNT_W-1:0] count,
  input  logic [rcba_pkg::BC_W-1:0]  block_count,
  input  logic                       busy,
  output logic                       cmd_valid,
  output rcba_pkg::cmd_t             cmd,
  input  logic                       cmd_pop
);
  rcba_pkg::cmd_t cls;
  logic           q_full;
  logic           q_empty;
  logic           bad_id;

  // Classification of the incoming item.
  always_comb begin
    bad_id        = (target_id == '0) ||
                    ({1'b0, target_id} >= block_count);
    cls.target_id = target_id;
    cls.count     = count;
    cls.kind      = rcba_pkg::K_BAD;
    if (operation == rcba_pkg::OP_ALLOC) begin
      if (count == '0) begin
        cls.kind = rcba_pkg::K_ZERO;
      end else if (int'(count) > MAX_ALLOC) begin
        cls.kind = rcba_pkg::K_SHORT;
      end else begin
        cls.kind = rcba_pkg::K_ALLOC;
      end
    end else if (!bad_id) begin
      case (operation)
        rcba_pkg::OP_FREE_REQ:   cls.kind = rcba_pkg::K_FREE_REQ;
        rcba_pkg::OP_FREE_CACHE: cls.kind = rcba_pkg::K_FREE_CACHE;
        rcba_pkg::OP_REF_REQ:    cls.kind = rcba_pkg::K_REF_REQ;
        rcba_pkg::OP_REF_CACHE:  cls.kind = rcba_pkg::K_REF_CACHE;
        default:                 cls.kind = rcba_pkg::K_BAD;
      endcase
    end
  end

  // Nothing is taken while the pool is being initialised.
  assign full      = q_full || busy;
  assign cmd_valid = !q_empty;

  rcba_fifo #(
    .WIDTH($bits(rcba_pkg::cmd_t)),
    .DEPTH(rcba_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && !busy),
    .wdata(cls),
    .full (q_full),
    .pop  (cmd_pop),
    .rdata(cmd),
    .empty(q_empty)
  );
endmodule

### rtl/core/rcba_back.sv
// ----------------------------------------------------------------------------
// rcba_back
// Executes queued commands against the free map and the counter memories.
// ----------------------------------------------------------------------------
module rcba_back #(
  parameter int POOL_CAPACITY = rcba_pkg::POOL_CAPACITY,
  parameter int REF_WIDTH     = rcba_pkg::REF_WIDTH,
  parameter int MAX_ALLOC     = rcba_pkg::MAX_ALLOC
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      init_start,
  input  logic [rcba_pkg::BC_W-1:0] block_count,
  input  logic                      cmd_valid,
  input  rcba_pkg::cmd_t            cmd,
  output logic                      cmd_pop,
  input  logic                      res_full,
  output logic                      res_push,
  output rcba_pkg::result_t         res,
  output logic                      busy
);
  localparam int IDX_W  = $clog2(POOL_CAPACITY);
  localparam int FW     = (POOL_CAPACITY >= 32) ? 32 : (2 ** IDX_W);
  localparam int BIT_W  = $clog2(FW);
  localparam int ROWS   = (POOL_CAPACITY + FW - 1) / FW;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int FT_W   = $clog2(POOL_CAPACITY + 1);
  localparam int NW     = $clog2(MAX_ALLOC + 1);
  localparam int AB_W   = (MAX_ALLOC > 1) ? $clog2(MAX_ALLOC) : 1;
  localparam logic [REF_WIDTH-1:0] REF_MAX = '1;

  function automatic logic [REF_WIDTH-1:0] sat_inc(input logic [REF_WIDTH-1:0] v);
    sat_inc = (v == REF_MAX) ? v : v + 1'b1;
  endfunction

  // Memories.
  logic [REF_WIDTH-1:0] tot_mem [POOL_CAPACITY];
  logic [REF_WIDTH-1:0] req_mem [POOL_CAPACITY];
  logic [FW-1:0]        fm_mem  [ROWS];
  logic [IDX_W-1:0]     idb_mem [MAX_ALLOC];

  rcba_pkg::state_t state, state_next;

  logic [IDX_W-1:0]     clr_ptr;
  logic [ROW_W-1:0]     row;
  logic [FW-1:0]        word;
  logic [NW-1:0]        n;
  logic [NW-1:0]        k;
  rcba_pkg::cmd_t       cur;
  logic [rcba_pkg::ST_W-1:0] status;
  logic [FT_W-1:0]      free_total;
  logic [FT_W-1:0]      avail_total;
  logic [IDX_W-1:0]     pick_id;

  // Memory port controls.
  logic                 ctr_we;
  logic [IDX_W-1:0]     ctr_waddr;
  logic [REF_WIDTH-1:0] tot_wdata;
  logic [REF_WIDTH-1:0] req_wdata;
  logic [IDX_W-1:0]     ctr_raddr;
  logic [REF_WIDTH-1:0] tot_rd;
  logic [REF_WIDTH-1:0] req_rd;
  logic                 fm_we;
  logic [ROW_W-1:0]     fm_waddr;
  logic [FW-1:0]        fm_wdata;
  logic                 fm_load;
  logic [ROW_W-1:0]     fm_raddr;
  logic [IDX_W-1:0]     idb_rd;

  // Derived values.
  logic                 any_free;
  logic [BIT_W-1:0]     low_bit;
  logic [IDX_W-1:0]     low_id;
  logic [FW-1:0]        init_row;
  logic [IDX_W-1:0]     cur_idx;
  logic [ROW_W-1:0]     cur_row;
  logic [BIT_W-1:0]     cur_bit;
  logic                 alloc_last;
  logic                 emit_last;
  logic                 clr_done;

  // Results of the counter update of one free or reference command.
  logic [REF_WIDTH-1:0] ex_tot;
  logic [REF_WIDTH-1:0] ex_req;
  logic [FW-1:0]        ex_word;
  logic                 ex_fm_we;
  logic [FT_W-1:0]      ex_free;
  logic [FT_W-1:0]      ex_avail;
  logic [rcba_pkg::ST_W-1:0] ex_status;

  assign cur_idx    = IDX_W'(cur.target_id);
  assign cur_row    = ROW_W'(cur_idx >> BIT_W);
  assign cur_bit    = BIT_W'(cur_idx);
  assign alloc_last = ((n + 1'b1) == NW'(cur.count));
  assign emit_last  = ((k + 1'b1) == n);
  assign clr_done   = (clr_ptr == IDX_W'(POOL_CAPACITY - 1));
  assign busy       = (state == rcba_pkg::S_INIT);

  // Lowest free block in the current free-map row.
  always_comb begin
    any_free = 1'b0;
    low_bit  = '0;
    for (int b = FW - 1; b >= 0; b--) begin
      if (word[b]) begin
        any_free = 1'b1;
        low_bit  = BIT_W'(b);
      end
    end
    low_id = IDX_W'(int'(row) * FW + int'(low_bit));
  end

  // Free-map row written during the clearing pass.
  always_comb begin
    for (int b = 0; b < FW; b++) begin
      init_row[b] = ((int'(ROW_W'(clr_ptr)) * FW + b) != 0) &&
                    ((int'(ROW_W'(clr_ptr)) * FW + b) < int'(block_count));
    end
  end

  // Counter and free-map update of a free or reference command.
  always_comb begin
    ex_tot    = tot_rd;
    ex_req    = req_rd;
    ex_word   = word;
    ex_fm_we  = 1'b0;
    ex_free   = free_total;
    ex_avail  = avail_total;
    ex_status = rcba_pkg::ST_OK;
    case (cur.kind)
      rcba_pkg::K_FREE_REQ, rcba_pkg::K_FREE_CACHE: begin
        if (tot_rd == '0) begin
          ex_status = rcba_pkg::ST_BAD;
        end else begin
          ex_tot = tot_rd - 1'b1;
          if ((ex_tot == '0) && !word[cur_bit]) begin
            ex_word[cur_bit] = 1'b1;
            ex_fm_we         = 1'b1;
            ex_free          = free_total + 1'b1;
          end
        end
        if (cur.kind == rcba_pkg::K_FREE_REQ) begin
          if (req_rd == '0) begin
            ex_status = rcba_pkg::ST_BAD;
          end else begin
            ex_req = req_rd - 1'b1;
            if (ex_req == '0) begin
              ex_avail = avail_total + 1'b1;
            end
          end
        end
      end
      rcba_pkg::K_REF_REQ: begin
        if ((req_rd == '0) && (avail_total != '0)) begin
          ex_avail = avail_total - 1'b1;
        end
        ex_req = sat_inc(req_rd);
        ex_tot = sat_inc(tot_rd);
      end
      rcba_pkg::K_REF_CACHE: begin
        ex_tot = sat_inc(tot_rd);
      end
      default: begin
        ex_status = rcba_pkg::ST_BAD;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rcba_pkg::S_INIT: begin
        if (clr_done) begin
          state_next = rcba_pkg::S_IDLE;
        end
      end
      rcba_pkg::S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            rcba_pkg::K_ALLOC: begin
              if (int'(free_total) < int'(cmd.count)) begin
                state_next = rcba_pkg::S_ONE;
              end else begin
                state_next = rcba_pkg::S_AROW;
              end
            end
            rcba_pkg::K_FREE_REQ, rcba_pkg::K_FREE_CACHE,
            rcba_pkg::K_REF_REQ, rcba_pkg::K_REF_CACHE: begin
              state_next = rcba_pkg::S_RMW_RD;
            end
            default: state_next = rcba_pkg::S_ONE;
          endcase
        end
      end
      rcba_pkg::S_ONE: begin
        if (!res_full) begin
          state_next = rcba_pkg::S_IDLE;
        end
      end
      rcba_pkg::S_AROW:   state_next = rcba_pkg::S_APICK;
      rcba_pkg::S_APICK: begin
        state_next = any_free ? rcba_pkg::S_AUPD : rcba_pkg::S_AROW;
      end
      rcba_pkg::S_AUPD: begin
        state_next = alloc_last ? rcba_pkg::S_ERD : rcba_pkg::S_APICK;
      end
      rcba_pkg::S_ERD:    state_next = rcba_pkg::S_EPUSH;
      rcba_pkg::S_EPUSH: begin
        if (!res_full) begin
          state_next = emit_last ? rcba_pkg::S_IDLE : rcba_pkg::S_ERD;
        end
      end
      rcba_pkg::S_RMW_RD: state_next = rcba_pkg::S_RMW_EX;
      rcba_pkg::S_RMW_EX: state_next = rcba_pkg::S_ONE;
      default:            state_next = rcba_pkg::S_INIT;
    endcase
  end

  // Memory ports and handshakes.
  always_comb begin
    ctr_we    = 1'b0;
    ctr_waddr = cur_idx;
    tot_wdata = ex_tot;
    req_wdata = ex_req;
    ctr_raddr = cur_idx;
    fm_we     = 1'b0;
    fm_waddr  = row;
    fm_wdata  = ex_word;
    fm_load   = 1'b0;
    fm_raddr  = row;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res.granted_block    = '0;
    res.last             = 1'b1;
    res.status           = status;
    res.free_blocks      = rcba_pkg::TOT_W'(free_total);
    res.available_blocks = rcba_pkg::TOT_W'(avail_total);
    case (state)
      rcba_pkg::S_INIT: begin
        ctr_we    = 1'b1;
        ctr_waddr = clr_ptr;
        tot_wdata = '0;
        req_wdata = '0;
        fm_we     = (int'(clr_ptr) < ROWS);
        fm_waddr  = ROW_W'(clr_ptr);
        fm_wdata  = init_row;
      end
      rcba_pkg::S_IDLE: begin
        cmd_pop = cmd_valid;
      end
      rcba_pkg::S_ONE: begin
        res_push = 1'b1;
      end
      rcba_pkg::S_AROW: begin
        fm_load = 1'b1;
      end
      rcba_pkg::S_APICK: begin
        ctr_raddr = low_id;
        if (any_free) begin
          fm_we    = 1'b1;
          fm_wdata = word & ~(FW'(1) << low_bit);
        end
      end
      rcba_pkg::S_AUPD: begin
        ctr_we    = 1'b1;
        ctr_waddr = pick_id;
        tot_wdata = sat_inc(tot_rd);
        req_wdata = sat_inc(req_rd);
      end
      rcba_pkg::S_EPUSH: begin
        res_push          = 1'b1;
        res.granted_block = rcba_pkg::ID_W'(idb_rd);
        res.last          = emit_last;
        res.status        = rcba_pkg::ST_OK;
      end
      rcba_pkg::S_RMW_RD: begin
        fm_load  = 1'b1;
        fm_raddr = cur_row;
      end
      rcba_pkg::S_RMW_EX: begin
        ctr_we   = 1'b1;
        fm_we    = ex_fm_we;
        fm_waddr = cur_row;
      end
      default: begin
        ctr_we = 1'b0;
      end
    endcase
  end

  // Counter memories.
  always_ff @(posedge clk) begin
    if (ctr_we) begin
      tot_mem[ctr_waddr] <= tot_wdata;
      req_mem[ctr_waddr] <= req_wdata;
    end
    tot_rd <= tot_mem[ctr_raddr];
    req_rd <= req_mem[ctr_raddr];
  end

  // Free map: a row is loaded into the working word, picks clear bits in it.
  always_ff @(posedge clk) begin
    if (fm_we) begin
      fm_mem[fm_waddr] <= fm_wdata;
    end
    if (fm_load) begin
      word <= fm_mem[fm_raddr];
    end else if (state == rcba_pkg::S_APICK && any_free) begin
      word <= word & ~(FW'(1) << low_bit);
    end
  end

  // Buffer of granted ids, read back while results are sent.
  always_ff @(posedge clk) begin
    if (state == rcba_pkg::S_AUPD) begin
      idb_mem[AB_W'(n)] <= pick_id;
    end
    idb_rd <= idb_mem[AB_W'(k)];
  end

  // Sequencer state and totals.
  always_ff @(posedge clk) begin
    if (rst || init_start) begin
      state       <= rcba_pkg::S_INIT;
      clr_ptr     <= '0;
      free_total  <= '0;
      avail_total <= '0;
    end else begin
      state <= state_next;
      case (state)
        rcba_pkg::S_INIT: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_done) begin
            free_total  <= FT_W'(block_count - 1'b1);
            avail_total <= FT_W'(block_count - 1'b1);
          end
        end
        rcba_pkg::S_AUPD: begin
          free_total <= free_total - 1'b1;
          if ((req_rd == '0) && (avail_total != '0)) begin
            avail_total <= avail_total - 1'b1;
          end
        end
        rcba_pkg::S_RMW_EX: begin
          free_total  <= ex_free;
          avail_total <= ex_avail;
        end
        default: begin
          free_total <= free_total;
        end
      endcase
    end
  end

  // Command latch and alloc progress.
  always_ff @(posedge clk) begin
    case (state)
      rcba_pkg::S_IDLE: begin
        cur <= cmd;
        n   <= '0;
        k   <= '0;
        row <= '0;
        case (cmd.kind)
          rcba_pkg::K_ALLOC: status <= rcba_pkg::ST_SHORT;
          rcba_pkg::K_SHORT: status <= rcba_pkg::ST_SHORT;
          rcba_pkg::K_ZERO:  status <= rcba_pkg::ST_OK;
          default:           status <= rcba_pkg::ST_BAD;
        endcase
      end
      rcba_pkg::S_APICK: begin
        pick_id <= low_id;
        if (!any_free) begin
          row <= row + 1'b1;
        end
      end
      rcba_pkg::S_AUPD: begin
        n <= n + 1'b1;
      end
      rcba_pkg::S_EPUSH: begin
        if (!res_full) begin
          k <= k + 1'b1;
        end
      end
      rcba_pkg::S_RMW_EX: begin
        status <= ex_status;
      end
      default: begin
        n <= n;
      end
    endcase
  end
endmodule

### rtl/core/refcounted_block_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_block_allocator: reference-counted block pool allocator.
// Free and reference commands read the counters and the free-map row, write them
// back updated, then push one result to the result queue.
// Alloc scans free-map rows of up to 32, claims each free block, then sends one result per grant.
// Reset or a block_count write starts a clearing pass over the pool (full).
// ----------------------------------------------------------------------------
module refcounted_block_allocator #(
  parameter int POOL_CAPACITY = rcba_pkg::POOL_CAPACITY,
  parameter int REF_WIDTH     = rcba_pkg::REF_WIDTH,
  parameter int MAX_ALLOC     = rcba_pkg::MAX_ALLOC
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [rcba_pkg::OP_W-1:0]   operation,
  input  logic [rcba_pkg::ID_W-1:0]   target_id,
  input  logic [rcba_pkg::CNT_W-1:0]  count,
  output logic                        empty,
  input  logic                        pop,
  output logic [rcba_pkg::ID_W-1:0]   granted_block,
  output logic                        last,
  output logic [rcba_pkg::ST_W-1:0]   status,
  output logic [rcba_pkg::TOT_W-1:0]  free_blocks,
  output logic [rcba_pkg::TOT_W-1:0]  available_blocks,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  localparam int BC_RESET = (rcba_pkg::BC_DEFAULT > POOL_CAPACITY) ?
                            POOL_CAPACITY : rcba_pkg::BC_DEFAULT;

  logic [rcba_pkg::BC_W-1:0] block_count;
  logic [rcba_pkg::BC_W-1:0] bc_wr;
  logic                      cfg_write;
  logic                      busy;
  logic                      cmd_valid;
  logic                      cmd_pop;
  rcba_pkg::cmd_t            cmd;
  logic                      res_push;
  logic                      res_full;
  rcba_pkg::result_t         res_in;
  rcba_pkg::result_t         res_out;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == rcba_pkg::REG_BLOCK_COUNT);
  assign prdata    = (paddr[2] == rcba_pkg::REG_BLOCK_COUNT) ?
                     {21'b0, block_count} : 32'b0;

  // Written value clamped to the pool.
  always_comb begin
    bc_wr = pwdata[rcba_pkg::BC_W-1:0];
    if (bc_wr < rcba_pkg::BC_W'(2)) begin
      bc_wr = rcba_pkg::BC_W'(2);
    end else if (int'(bc_wr) > POOL_CAPACITY) begin
      bc_wr = rcba_pkg::BC_W'(POOL_CAPACITY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= rcba_pkg::BC_W'(BC_RESET);
    end else if (cfg_write) begin
      block_count <= bc_wr;
    end
  end

  rcba_front #(
    .MAX_ALLOC(MAX_ALLOC)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .target_id  (target_id),
    .count      (count),
    .block_count(block_count),
    .busy       (busy),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  rcba_back #(
    .POOL_CAPACITY(POOL_CAPACITY),
    .REF_WIDTH    (REF_WIDTH),
    .MAX_ALLOC    (MAX_ALLOC)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .init_start (cfg_write),
    .block_count(block_count),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in),
    .busy       (busy)
  );

  // Result queue towards the consumer.
  rcba_fifo #(
    .WIDTH($bits(rcba_pkg::result_t)),
    .DEPTH(rcba_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_out),
    .empty(empty)
  );

  assign granted_block    = res_out.granted_block;
  assign last             = res_out.last;
  assign status           = res_out.status;
  assign free_blocks      = res_out.free_blocks;
  assign available_blocks = res_out.available_blocks;
endmodule

### rtl/core/rcba_checker.sv
// ----------------------------------------------------------------------------
// rcba_checker
// Port-level checks of the block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "refcounted_block_allocator_defines.svh"

module rcba_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       full,
  input logic                       empty,
  input logic                       pop,
  input logic [rcba_pkg::ID_W-1:0]  granted_block,
  input logic                       last,
  input logic [rcba_pkg::ST_W-1:0]  status,
  input logic                       pready
);
  // The clearing pass holds off input straight after reset.
  `RCBA_ASSERT_NEXT_ALWAYS(a_full_after_rst, rst, full)

  // A waiting result stays put until it is taken.
  `RCBA_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(granted_block))

  // A failed transaction is a single result with no grant.
  `RCBA_ASSERT_IMPL(a_fail_single, !empty && (status != rcba_pkg::ST_OK),
                    last && (granted_block == '0))

  // The configuration port never waits.
  `RCBA_ASSERT_IMPL(a_pready, 1'b1, pready)
endmodule

bind refcounted_block_allocator rcba_checker u_rcba_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .granted_block(granted_block),
  .last         (last),
  .status       (status),
  .pready       (pready)
);
